/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* sv/upe_pkg.sv */
// ----------------------------------------------------------------------------
// upe_pkg
// Types, constants and helper functions shared by the URL percent encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package upe_pkg;

  // Configuration register indexes.
  localparam logic CFG_UPPER_CASE   = 1'b0;
  localparam logic CFG_BUF_CAPACITY = 1'b1;

  // Register reset values.
  localparam logic        UPPER_CASE_RESET   = 1'b1;
  localparam logic [15:0] BUF_CAPACITY_RESET = 16'd256;

  // Depth of the command queue between the front and back halves.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character constants.
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Kind of work handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_PLAIN = 2'd0,
    CMD_ESC   = 2'd1,
    CMD_TERM  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       upper;
    logic       trunc;
  } cmd_t;

  // Output sequencer phase.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_HEX_HI = 2'd1,
    PH_HEX_LO = 2'd2
  } phase_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // ASCII hex digit of a nibble, letter case selectable.
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? 8'h41 : 8'h61;
    if (nib >= 4'hA) begin
      hex_char = base + {4'd0, nib} - 8'd10;
    end else begin
      hex_char = 8'h30 + {4'd0, nib};
    end
  endfunction

  // Bytes that pass through unescaped (C locale letters, digits, - . ~).
  function automatic logic passes_plain(input logic [7:0] c);
    passes_plain = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h30 && c <= 8'h39) || c == CH_MINUS ||
                   c == CH_DOT || c == CH_TILDE;
  endfunction

endpackage

/* sv/upe_front.sv */
// ----------------------------------------------------------------------------
// upe_front
// Accepts input transactions, checks them against the buffer capacity and
// queues one command for each transaction that produces output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upe_front import upe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        upper_case,
  input  logic [15:0] buf_capacity,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_end,
  input  logic [7:0]  in_byte,
  input  q_status_t   q_status,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [15:0] written_count;
  logic [15:0] written_count_next;
  logic        stopped;
  logic        stopped_next;
  logic [15:0] room;
  logic        accept;
  logic        esc_fits;
  logic        plain_ok;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Space left for text, one byte kept for the terminator.
  assign room     = (buf_capacity == 16'd0) ? 16'd0 : buf_capacity - 16'd1;
  assign esc_fits = ({1'b0, written_count} + 17'd3) <= {1'b0, room};
  assign plain_ok = passes_plain(in_byte) || in_byte == CH_SPACE;

  // Classify the transaction and update the running count.
  always_comb begin
    written_count_next = written_count;
    stopped_next       = stopped;
    push               = 1'b0;
    push_cmd.kind      = CMD_PLAIN;
    push_cmd.data      = (in_byte == CH_SPACE) ? CH_PLUS : in_byte;
    push_cmd.upper     = upper_case;
    push_cmd.trunc     = stopped;
    if (accept) begin
      if (in_end) begin
        push               = 1'b1;
        push_cmd.kind      = CMD_TERM;
        written_count_next = 16'd0;
        stopped_next       = 1'b0;
      end else if (stopped || written_count >= room) begin
        stopped_next = 1'b1;
      end else if (plain_ok) begin
        push               = 1'b1;
        written_count_next = written_count + 16'd1;
      end else if (!esc_fits) begin
        stopped_next = 1'b1;
      end else begin
        push               = 1'b1;
        push_cmd.kind      = CMD_ESC;
        push_cmd.data      = in_byte;
        written_count_next = written_count + 16'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written_count <= 16'd0;
      stopped       <= 1'b0;
    end else begin
      written_count <= written_count_next;
      stopped       <= stopped_next;
    end
  end

endmodule

/* sv/upe_queue.sv */
// ----------------------------------------------------------------------------
// upe_queue
// Small command FIFO that decouples the classifier from the output sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upe_queue import upe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* sv/upe_back.sv */
// ----------------------------------------------------------------------------
// upe_back
// Expands queued commands into output bytes, one per cycle while commands are
// queued and the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upe_back import upe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_term,
  output logic       out_trunc
);

  phase_t     phase;
  phase_t     phase_next;
  logic       step;
  logic       out_valid_next;
  logic [7:0] out_byte_next;
  logic       out_last_next;
  logic       out_term_next;
  logic       out_trunc_next;

  // The output register takes a new byte whenever a command is queued and the register is empty or being drained.
  assign step = head_valid && (!out_valid || out_ready);

  // Next phase and the byte produced for the head command.
  always_comb begin
    phase_next     = phase;
    pop            = 1'b0;
    out_valid_next = out_valid && !out_ready;
    out_byte_next  = out_byte;
    out_last_next  = out_last;
    out_term_next  = out_term;
    out_trunc_next = out_trunc;
    if (step) begin
      out_valid_next = 1'b1;
      out_term_next  = 1'b0;
      out_trunc_next = 1'b0;
      out_last_next  = 1'b0;
      case (phase)
        PH_FIRST: begin
          case (head.kind)
            CMD_TERM: begin
              out_byte_next  = CH_NUL;
              out_last_next  = 1'b1;
              out_term_next  = 1'b1;
              out_trunc_next = head.trunc;
              pop            = 1'b1;
            end
            CMD_ESC: begin
              out_byte_next = CH_PERCENT;
              phase_next    = PH_HEX_HI;
            end
            default: begin
              out_byte_next = head.data;
              out_last_next = 1'b1;
              pop           = 1'b1;
            end
          endcase
        end
        PH_HEX_HI: begin
          out_byte_next = hex_char(head.data[7:4], head.upper);
          phase_next    = PH_HEX_LO;
        end
        PH_HEX_LO: begin
          out_byte_next = hex_char(head.data[3:0], head.upper);
          out_last_next = 1'b1;
          pop           = 1'b1;
          phase_next    = PH_FIRST;
        end
        default: begin
          phase_next = PH_FIRST;
        end
      endcase
    end
  end

  // Phase and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    out_byte  <= out_byte_next;
    out_last  <= out_last_next;
    out_term  <= out_term_next;
    out_trunc <= out_trunc_next;
  end

endmodule

/* sv/url_percent_encoder.sv */
// ----------------------------------------------------------------------------
// url_percent_encoder
// Streaming URL percent encoder with a bounded output buffer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction fields
//  s_axis    in         tlast = end_marker, tdata = data_byte
//  m_axis    out        tdata = out_byte, tlast = run_last,
//                       tuser = {truncated, is_terminator}
//  cfg       in         index 0 upper_case, index 1 buf_capacity
//
// An input transaction is classified in the cycle it is accepted and its
// command queued; the sequencer gives one byte per cycle while the output is
// not stalled: one for a plain byte or terminator, three for an escaped byte.
// Input is accepted every cycle while the 4-entry command queue has room.
// Reset (synchronous) clears the count, the stop flag, the queue and the
// output register, and loads upper_case = 1 and buf_capacity = 256.
// Either side may stall without losing or repeating a transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module url_percent_encoder import upe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [0] is_terminator, [1] truncated
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic        upper_case;
  logic [15:0] buf_capacity;
  logic        push;
  cmd_t        push_cmd;
  logic        pop;
  cmd_t        head;
  q_status_t   q_status;
  logic        is_term;
  logic        trunc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_case   <= UPPER_CASE_RESET;
      buf_capacity <= BUF_CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPPER_CASE:   upper_case   <= cfg_data[0];
        CFG_BUF_CAPACITY: buf_capacity <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  upe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .upper_case   (upper_case),
    .buf_capacity (buf_capacity),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_end       (s_axis_tlast),
    .in_byte      (s_axis_tdata),
    .q_status     (q_status),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  upe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  upe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_status.empty),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_term   (is_term),
    .out_trunc  (trunc)
  );

  assign m_axis_tuser = {trunc, is_term};

endmodule

/* sv/upe_checker.sv */
// ----------------------------------------------------------------------------
// upe_checker
// Port-level checks on the URL percent encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upe_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  // A stalled output transaction stays offered.
  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // Nothing is offered in the cycle after reset.
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_axis_tvalid)

  // The terminator is a NUL and closes its run.
  `ASSERT_CLK(a_term_shape, clk, rst,
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'h00)

  // The truncated flag appears only on the terminator.
  `ASSERT_CLK(a_trunc_on_term, clk, rst, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])

  // Encoded text never contains a NUL byte.
  `ASSERT_CLK(a_text_nonzero, clk, rst,
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata != 8'h00)

endmodule

bind url_percent_encoder upe_checker u_upe_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
